// ----- sv/rtem_pkg.sv -----
// shared types, field widths and status codes for the exact-match route table
package rtem_pkg;

    // default number of table entries
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // field widths
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 8;
    localparam int LIFE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // stream widths
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = STATUS_W;

    // operation kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // payload of one route entry, besides its key
    typedef struct packed {
        logic [ADDR_W-1:0] net_mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port_number;
        logic [LIFE_W-1:0] lifetime;
    } t_entry;

    // search token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] key;
        logic              hit;
        logic              free;
        t_entry            old;
    } t_token;

    // write command broadcast to the cells, steered by an index
    typedef struct packed {
        logic              ins;
        logic              upd;
        logic              del;
        logic [ADDR_W-1:0] key;
        t_entry            entry;
    } t_wr_cmd;

endpackage

// ----- sv/rtem_cell.sv -----
// one table entry with its search stage in the cell chain
module rtem_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtem_pkg::t_token     i_tok,
    input  logic [IDX_W-1:0]     i_hit_idx,
    input  logic [IDX_W-1:0]     i_free_idx,
    output rtem_pkg::t_token     o_tok,
    output logic [IDX_W-1:0]     o_hit_idx,
    output logic [IDX_W-1:0]     o_free_idx,
    input  rtem_pkg::t_wr_cmd    i_wr,
    input  logic [IDX_W-1:0]     i_wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                        r_valid;
    logic [rtem_pkg::ADDR_W-1:0] r_target;
    rtem_pkg::t_entry            r_entry;

    rtem_pkg::t_token r_tok;
    rtem_pkg::t_token n_tok;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] n_hit_idx;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] n_free_idx;

    logic match;
    logic wr_sel;

    // compare against this entry, first hit and first free slot win
    assign match = r_valid && (r_target == i_tok.key);

    always_comb begin
        n_tok      = i_tok;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        if (!i_tok.hit && match) begin
            n_tok.hit = 1'b1;
            n_tok.old = r_entry;
            n_hit_idx = MY_IDX;
        end
        if (!i_tok.free && !r_valid) begin
            n_tok.free = 1'b1;
            n_free_idx = MY_IDX;
        end
    end

    // token stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok      <= n_tok;
            r_hit_idx  <= n_hit_idx;
            r_free_idx <= n_free_idx;
        end
    end

    assign o_tok      = r_tok;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

    // entry storage, written by the broadcast command
    assign wr_sel = (i_wr_idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_sel) begin
            if (i_wr.ins) begin
                r_valid  <= 1'b1;
                r_target <= i_wr.key;
                r_entry  <= i_wr.entry;
            end
            if (i_wr.upd) begin
                r_entry.lifetime <= i_wr.entry.lifetime;
            end
            if (i_wr.del) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/route_table_exact_match_store.sv -----
// Exact-match route table built as a chain of entry cells.
// Input stream (s_*): one beat is one add/update or remove request; tuser
// carries the kind (0 add or update, 1 remove), tdata the target, mask,
// gateway, interface and lifetime. Output stream (m_*): one beat per
// request; tuser carries the status, tdata the entry count after the
// operation and the fields of a removed entry (zero otherwise).
// A request travels the chain one cell per cycle, so a search passes every
// cell; the decision at the chain's end applies the write and forms the
// result, and the result is loaded into the output register once it frees.
// The next request is taken only after that load.
// s_tready is high only while no request is in the chain.
// Reset (synchronous, active low) clears every valid bit, the entry count
// and the output valid; the table is usable in the next cycle.
// When the receiver stalls, the finished result waits in the output
// register; a new request may still be taken and searched, and its result
// waits in the control logic until the output register frees.
module route_table_exact_match_store #(
    parameter int TABLE_DEPTH = rtem_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // target[31:0], net_mask[63:32], gateway[95:64], port_number[103:96],
    // lifetime[119:104]
    input  logic [rtem_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic [rtem_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // entry_count[4:0], old_mask[36:5], old_gateway[68:37], old_port[76:69],
    // old_lifetime[92:77], zero[95:93]
    output logic [rtem_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [rtem_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // held request
    logic                        r_kind;
    logic [rtem_pkg::ADDR_W-1:0] r_key;
    rtem_pkg::t_entry            r_req;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // pending result
    logic [rtem_pkg::STATUS_W-1:0] r_res_status;
    logic [rtem_pkg::STATUS_W-1:0] n_res_status;
    rtem_pkg::t_entry              r_res_old;
    rtem_pkg::t_entry              n_res_old;

    // output register
    logic                          r_out_vld;
    logic [rtem_pkg::STATUS_W-1:0] r_out_status;
    logic [rtem_pkg::COUNT_W-1:0]  r_out_count;
    rtem_pkg::t_entry              r_out_old;

    rtem_pkg::t_token  w_tok      [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  w_hit_idx  [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  w_free_idx [0:TABLE_DEPTH];
    rtem_pkg::t_wr_cmd n_wr;
    rtem_pkg::t_wr_cmd w_wr;
    logic [IDX_W-1:0]  n_wr_idx;

    logic s_acc;
    logic decide;
    logic out_load;

    rtem_pkg::t_token tok_end;

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign tok_end  = w_tok[TABLE_DEPTH];
    assign decide   = (r_state == S_SCAN) && tok_end.vld;
    assign out_load = (r_state == S_OUT) && (!r_out_vld || m_tready);

    // inject the search token into the first cell
    always_comb begin
        w_tok[0]      = '0;
        w_tok[0].vld  = s_acc;
        w_tok[0].key  = s_tdata[31:0];
        w_hit_idx[0]  = '0;
        w_free_idx[0] = '0;
    end

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rtem_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_hit_idx  (w_hit_idx[g]),
            .i_free_idx (w_free_idx[g]),
            .o_tok      (w_tok[g+1]),
            .o_hit_idx  (w_hit_idx[g+1]),
            .o_free_idx (w_free_idx[g+1]),
            .i_wr       (w_wr),
            .i_wr_idx   (n_wr_idx)
        );
    end

    // decision at the end of the chain
    always_comb begin
        n_wr         = '0;
        n_wr.key     = r_key;
        n_wr.entry   = r_req;
        n_wr_idx     = w_hit_idx[TABLE_DEPTH];
        n_count      = r_count;
        n_res_status = rtem_pkg::ST_NOTFOUND;
        n_res_old    = '0;
        if (r_kind == rtem_pkg::KIND_ADD) begin
            if (tok_end.hit) begin
                n_wr.upd     = 1'b1;
                n_res_status = rtem_pkg::ST_UPDATED;
            end else if (tok_end.free) begin
                n_wr.ins     = 1'b1;
                n_wr_idx     = w_free_idx[TABLE_DEPTH];
                n_count      = r_count + CNT_W'(1);
                n_res_status = rtem_pkg::ST_INSERTED;
            end else begin
                n_res_status = rtem_pkg::ST_FULL;
            end
        end else begin
            if (tok_end.hit) begin
                n_wr.del     = 1'b1;
                n_count      = r_count - CNT_W'(1);
                n_res_status = rtem_pkg::ST_REMOVED;
                n_res_old    = tok_end.old;
            end
        end
    end

    // write command goes out only in the decision cycle
    always_comb begin
        w_wr = n_wr;
        if (!decide) begin
            w_wr.ins = 1'b0;
            w_wr.upd = 1'b0;
            w_wr.del = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (decide) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (decide) begin
                r_count <= n_count;
            end
        end
    end

    // request and pending result capture
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind               <= s_tuser[0];
            r_key                <= s_tdata[31:0];
            r_req.net_mask       <= s_tdata[63:32];
            r_req.gateway        <= s_tdata[95:64];
            r_req.port_number    <= s_tdata[103:96];
            r_req.lifetime       <= s_tdata[119:104];
        end
        if (decide) begin
            r_res_status <= n_res_status;
            r_res_old    <= n_res_old;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_count  <= rtem_pkg::COUNT_W'(r_count);
            r_out_old    <= r_res_old;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {3'b000,
                       r_out_old.lifetime,
                       r_out_old.port_number,
                       r_out_old.gateway,
                       r_out_old.net_mask,
                       r_out_count};

endmodule

// ----- sv/rtem_checker.sv -----
// port-level checks for the route table, bound to the top level
module rtem_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtem_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rtem_pkg::M_TUSER_W-1:0] m_tuser
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output beat valid right after reset");

    // one request in flight: an accepted beat closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in the chain");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // status is a known code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == rtem_pkg::ST_INSERTED || m_tuser == rtem_pkg::ST_UPDATED
                      || m_tuser == rtem_pkg::ST_REMOVED || m_tuser == rtem_pkg::ST_NOTFOUND
                      || m_tuser == rtem_pkg::ST_FULL))
        else $error("unknown status code");

    // only a removal returns entry fields
    a_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != rtem_pkg::ST_REMOVED) |-> (m_tdata[95:5] == '0))
        else $error("entry fields set without a removal");

endmodule

bind route_table_exact_match_store rtem_checker u_rtem_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
